### rtl/gclf_pkg.sv
// Package for the G-code line framer: character codes, microcode word layout,
// sequencer status, the control program and small conversion functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gclf_pkg;

  localparam int GCLF_LINE_CAPACITY = 48;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_PAREN = 8'h28;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef logic [3:0] step_t;

  localparam step_t ST_IDLE   = 4'd0;
  localparam step_t ST_N      = 4'd1;
  localparam step_t ST_NSKIP  = 4'd2;
  localparam step_t ST_NDIG   = 4'd3;
  localparam step_t ST_SP     = 4'd4;
  localparam step_t ST_RD     = 4'd5;
  localparam step_t ST_BYTE   = 4'd6;
  localparam step_t ST_NCHK   = 4'd7;
  localparam step_t ST_STAR   = 4'd8;
  localparam step_t ST_CKSKIP = 4'd9;
  localparam step_t ST_CKDIG  = 4'd10;
  localparam step_t ST_FIN    = 4'd11;

  typedef enum logic [2:0] {
    E_NONE, E_N, E_NUM_DIG, E_SP, E_BYTE, E_STAR, E_CK_DIG
  } emit_t;

  typedef enum logic [2:0] {
    C_NONE, C_ALWAYS, C_NUM_LEADZ, C_CK_LEADZ, C_DIG_MORE, C_BYTE_MORE, C_NUM_OFF
  } cond_t;

  typedef enum logic [1:0] {
    D_HOLD, D_LOAD4, D_LOAD2, D_DEC_ON_JUMP
  } dig_op_t;

  typedef struct packed {
    emit_t   emit;
    logic    rd;
    dig_op_t dig_op;
    logic    load_ck;
    logic    finish;
    cond_t   cond;
    step_t   target;
  } ctrl_word_t;

  typedef struct packed {
    logic stall;
    logic start;
    logic num_leadz;
    logic ck_leadz;
    logic dig_more;
    logic byte_more;
    logic num_off;
  } seq_status_t;

  typedef struct packed {
    ctrl_word_t word;
    logic       idle;
    logic       advance;
    logic       jump;
  } seq_ctrl_t;

  function automatic ctrl_word_t cw(emit_t e, logic rd, dig_op_t d, logic ck, logic fin,
                                    cond_t c, step_t t);
    ctrl_word_t w;
    w.emit    = e;
    w.rd      = rd;
    w.dig_op  = d;
    w.load_ck = ck;
    w.finish  = fin;
    w.cond    = c;
    w.target  = t;
    return w;
  endfunction

  function automatic ctrl_word_t program_rom(step_t s);
    ctrl_word_t w;
    unique case (s)
      ST_N:      w = cw(E_N,       1'b0, D_LOAD4,       1'b0, 1'b0, C_NONE,      ST_IDLE);
      ST_NSKIP:  w = cw(E_NONE,    1'b0, D_DEC_ON_JUMP, 1'b0, 1'b0, C_NUM_LEADZ, ST_NSKIP);
      ST_NDIG:   w = cw(E_NUM_DIG, 1'b0, D_DEC_ON_JUMP, 1'b0, 1'b0, C_DIG_MORE,  ST_NDIG);
      ST_SP:     w = cw(E_SP,      1'b0, D_HOLD,        1'b0, 1'b0, C_NONE,      ST_IDLE);
      ST_RD:     w = cw(E_NONE,    1'b1, D_HOLD,        1'b0, 1'b0, C_NONE,      ST_IDLE);
      ST_BYTE:   w = cw(E_BYTE,    1'b0, D_HOLD,        1'b0, 1'b0, C_BYTE_MORE, ST_RD);
      ST_NCHK:   w = cw(E_NONE,    1'b0, D_HOLD,        1'b0, 1'b0, C_NUM_OFF,   ST_FIN);
      ST_STAR:   w = cw(E_STAR,    1'b0, D_LOAD2,       1'b1, 1'b0, C_NONE,      ST_IDLE);
      ST_CKSKIP: w = cw(E_NONE,    1'b0, D_DEC_ON_JUMP, 1'b0, 1'b0, C_CK_LEADZ,  ST_CKSKIP);
      ST_CKDIG:  w = cw(E_CK_DIG,  1'b0, D_DEC_ON_JUMP, 1'b0, 1'b0, C_DIG_MORE,  ST_CKDIG);
      ST_FIN:    w = cw(E_NONE,    1'b0, D_HOLD,        1'b0, 1'b1, C_ALWAYS,    ST_IDLE);
      default:   w = cw(E_NONE,    1'b0, D_HOLD,        1'b0, 1'b0, C_NONE,      ST_IDLE);
    endcase
    return w;
  endfunction

  // binary to three BCD digits, shift and add-3
  function automatic logic [11:0] bin8_to_bcd(logic [7:0] v);
    logic [19:0] sh;
    sh = {12'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (sh[11:8] > 4'd4) sh[11:8] = sh[11:8] + 4'd3;
      if (sh[15:12] > 4'd4) sh[15:12] = sh[15:12] + 4'd3;
      if (sh[19:16] > 4'd4) sh[19:16] = sh[19:16] + 4'd3;
      sh = sh << 1;
    end
    return sh[19:8];
  endfunction

endpackage

`default_nettype wire

### rtl/gclf_if.sv
// Handshake channel interfaces for the G-code line framer: input byte
// channel and output character channel. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface gclf_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] in_byte;

  modport source (output valid, output mode, output in_byte, input ready);
  modport sink (input valid, input mode, input in_byte, output ready);
endinterface

interface gclf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last;
  logic [15:0] line_number;

  modport source (output valid, output out_byte, output last, output line_number,
                  input ready);
  modport sink (input valid, input out_byte, input last, input line_number,
                output ready);
endinterface

`default_nettype wire

### rtl/gclf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gclf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/gclf_seq.sv
// Microcode sequencer: step counter, control program lookup and conditional
// jumps. Depends on gclf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gclf_seq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire gclf_pkg::seq_status_t status,
  output      gclf_pkg::seq_ctrl_t   ctrl
);

  gclf_pkg::step_t      step;
  gclf_pkg::ctrl_word_t word;
  logic                 cond_true;
  logic                 idle;
  logic                 advance;

  assign word    = gclf_pkg::program_rom(step);
  assign idle    = (step == gclf_pkg::ST_IDLE);
  assign advance = !idle && !status.stall;

  always_comb begin
    unique case (word.cond)
      gclf_pkg::C_NONE:      cond_true = 1'b0;
      gclf_pkg::C_ALWAYS:    cond_true = 1'b1;
      gclf_pkg::C_NUM_LEADZ: cond_true = status.num_leadz;
      gclf_pkg::C_CK_LEADZ:  cond_true = status.ck_leadz;
      gclf_pkg::C_DIG_MORE:  cond_true = status.dig_more;
      gclf_pkg::C_BYTE_MORE: cond_true = status.byte_more;
      gclf_pkg::C_NUM_OFF:   cond_true = status.num_off;
      default:               cond_true = 1'b0;
    endcase
  end

  assign ctrl.word    = word;
  assign ctrl.idle    = idle;
  assign ctrl.advance = advance;
  assign ctrl.jump    = advance && cond_true;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= gclf_pkg::ST_IDLE;
    end else if (idle) begin
      if (status.start) begin
        step <= status.num_off ? gclf_pkg::ST_RD : gclf_pkg::ST_N;
      end
    end else if (advance) begin
      step <= cond_true ? word.target : gclf_pkg::step_t'(step + 4'd1);
    end
  end

endmodule

`default_nettype wire

### rtl/gclf_top_note.sv
// Line-number BCD counter: decimal image of the command counter, kept in
// step with it and wrapping with it at 16 bits. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gclf_bcd_cnt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        clear,
  input  wire logic        incr,
  output      logic [15:0] count,
  output      logic [19:0] digits
);

  logic [19:0] digits_next;
  logic        carry;

  always_comb begin
    digits_next = digits;
    carry       = 1'b1;
    for (int d = 0; d < 5; d++) begin
      if (carry) begin
        if (digits[4*d +: 4] == 4'd9) begin
          digits_next[4*d +: 4] = 4'd0;
        end else begin
          digits_next[4*d +: 4] = digits[4*d +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count  <= 16'd0;
      digits <= 20'd0;
    end else if (incr) begin
      count  <= count + 16'd1;
      digits <= (count == 16'hFFFF) ? 20'd0 : digits_next;
    end
  end

endmodule

`default_nettype wire

### rtl/gcode_line_framer.sv
// Top level of the G-code line framer: line store, comment filter, trim
// tracking, output register and datapath driven by the microcode sequencer.
// Depends on gclf_pkg, gclf_if, gclf_ram, gclf_seq, gclf_bcd_cnt.
//
//   channel      dir  handshake      payload
//   in_items     in   valid/ready    mode, in_byte
//   out_items    out  valid/ready    out_byte, last, line_number
//   add_line_numbers_we  in  write strobe, add_line_numbers as data
//
// A byte other than newline is accepted whenever ready is high, and ready is
// high while the sequencer is at rest. A newline that closes a non-blank line
// starts a burst: each line character is read from the store, then emitted;
// prefix and suffix characters are emitted directly; skipped leading zeros and
// bookkeeping take steps of their own. Input is held off for the whole burst.
// Synchronous reset clears the counter, line state and control; a stalled
// output holds the sequencer on its emitting step.
`timescale 1ns / 1ps
`default_nettype none

module gcode_line_framer #(
  parameter int LINE_CAPACITY = gclf_pkg::GCLF_LINE_CAPACITY
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic add_line_numbers_we,
  input  wire logic add_line_numbers,
  gclf_in_if.sink   in_items,
  gclf_out_if.source out_items
);

  localparam int AW = $clog2(LINE_CAPACITY);
  localparam int LW = $clog2(LINE_CAPACITY + 1);

  logic           numbers_on;
  logic [LW-1:0]  line_length;
  logic [LW-1:0]  trim_len;
  logic           in_comment;
  logic [LW-1:0]  idx;
  logic [2:0]     dig;
  logic [7:0]     xsum;
  logic [11:0]    ck_bcd;
  logic           out_valid;
  logic [7:0]     out_byte;
  logic           out_last;
  logic [15:0]    out_number;

  logic [15:0]    line_counter;
  logic [19:0]    num_bcd;
  logic           cnt_clear;

  gclf_pkg::seq_status_t status;
  gclf_pkg::seq_ctrl_t   ctrl;

  logic           accept;
  logic           is_nl;
  logic           is_ws;
  logic           store_en;
  logic           start;
  logic [7:0]     rdata;
  logic [3:0]     num_digit;
  logic [3:0]     ck_digit;
  logic [7:0]     emit_char;
  logic           emit_last;
  logic           emit_go;
  logic           stall;

  assign accept   = in_items.valid && in_items.ready;
  assign is_nl    = (in_items.in_byte == gclf_pkg::CH_NL);
  assign is_ws    = (in_items.in_byte == gclf_pkg::CH_SPACE) ||
                    (in_items.in_byte >= 8'h09 && in_items.in_byte <= 8'h0D);
  assign store_en = accept && !in_items.mode && !is_nl && !in_comment &&
                    (in_items.in_byte != gclf_pkg::CH_SEMI) &&
                    (in_items.in_byte != gclf_pkg::CH_PAREN) &&
                    (line_length < LW'(LINE_CAPACITY));
  assign start    = accept && !in_items.mode && is_nl && (trim_len != '0);

  assign stall = (ctrl.word.emit != gclf_pkg::E_NONE) && out_valid && !out_items.ready;

  always_comb begin
    unique case (dig)
      3'd0:    num_digit = num_bcd[3:0];
      3'd1:    num_digit = num_bcd[7:4];
      3'd2:    num_digit = num_bcd[11:8];
      3'd3:    num_digit = num_bcd[15:12];
      default: num_digit = num_bcd[19:16];
    endcase
    unique case (dig[1:0])
      2'd0:    ck_digit = ck_bcd[3:0];
      2'd1:    ck_digit = ck_bcd[7:4];
      default: ck_digit = ck_bcd[11:8];
    endcase
  end

  assign status.stall     = stall;
  assign status.start     = start;
  assign status.num_leadz = (num_digit == 4'd0) && (dig != 3'd0);
  assign status.ck_leadz  = (ck_digit == 4'd0) && (dig != 3'd0);
  assign status.dig_more  = (dig != 3'd0);
  assign status.byte_more = (LW'(idx + LW'(1)) != trim_len);
  assign status.num_off   = !numbers_on;

  gclf_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  gclf_ram #(
    .WIDTH (8),
    .DEPTH (LINE_CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (store_en),
    .waddr (line_length[AW-1:0]),
    .wdata (in_items.in_byte),
    .re    (ctrl.advance && ctrl.word.rd),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  assign cnt_clear = accept && in_items.mode;

  gclf_bcd_cnt u_cnt (
    .clk    (clk),
    .rst    (rst),
    .clear  (cnt_clear),
    .incr   (ctrl.advance && ctrl.word.finish),
    .count  (line_counter),
    .digits (num_bcd)
  );

  always_comb begin
    emit_char = rdata;
    emit_last = 1'b0;
    unique case (ctrl.word.emit)
      gclf_pkg::E_NONE:    emit_char = rdata;
      gclf_pkg::E_N:       emit_char = gclf_pkg::CH_N;
      gclf_pkg::E_NUM_DIG: emit_char = gclf_pkg::CH_ZERO | {4'd0, num_digit};
      gclf_pkg::E_SP:      emit_char = gclf_pkg::CH_SPACE;
      gclf_pkg::E_BYTE: begin
        emit_char = rdata;
        emit_last = !status.byte_more && !numbers_on;
      end
      gclf_pkg::E_STAR:    emit_char = gclf_pkg::CH_STAR;
      gclf_pkg::E_CK_DIG: begin
        emit_char = gclf_pkg::CH_ZERO | {4'd0, ck_digit};
        emit_last = (dig == 3'd0);
      end
      default:             emit_char = rdata;
    endcase
  end

  assign emit_go = ctrl.advance && (ctrl.word.emit != gclf_pkg::E_NONE);

  assign in_items.ready        = ctrl.idle;
  assign out_items.valid       = out_valid;
  assign out_items.out_byte    = out_byte;
  assign out_items.last        = out_last;
  assign out_items.line_number = out_number;

  always_ff @(posedge clk) begin
    if (rst) begin
      numbers_on  <= 1'b1;
      line_length <= '0;
      trim_len    <= '0;
      in_comment  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (add_line_numbers_we) begin
        numbers_on <= add_line_numbers;
      end
      if (accept) begin
        if (in_items.mode) begin
          line_length <= '0;
          trim_len    <= '0;
          in_comment  <= 1'b0;
        end else if (is_nl) begin
          in_comment <= 1'b0;
          if (!start) begin
            line_length <= '0;
            trim_len    <= '0;
          end
        end else if (!in_comment && (in_items.in_byte == gclf_pkg::CH_SEMI ||
                                     in_items.in_byte == gclf_pkg::CH_PAREN)) begin
          in_comment <= 1'b1;
        end
      end
      if (store_en) begin
        line_length <= LW'(line_length + LW'(1));
        if (!is_ws) begin
          trim_len <= LW'(line_length + LW'(1));
        end
      end
      if (ctrl.advance && ctrl.word.finish) begin
        line_length <= '0;
        trim_len    <= '0;
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_items.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx  <= '0;
      xsum <= 8'd0;
    end
    if (emit_go) begin
      out_byte   <= emit_char;
      out_last   <= emit_last;
      out_number <= line_counter;
      if (ctrl.word.emit == gclf_pkg::E_N || ctrl.word.emit == gclf_pkg::E_NUM_DIG ||
          ctrl.word.emit == gclf_pkg::E_SP || ctrl.word.emit == gclf_pkg::E_BYTE) begin
        xsum <= xsum ^ emit_char;
      end
      if (ctrl.word.emit == gclf_pkg::E_BYTE) begin
        idx <= LW'(idx + LW'(1));
      end
    end
    if (ctrl.advance && ctrl.word.load_ck) begin
      ck_bcd <= gclf_pkg::bin8_to_bcd(xsum);
    end
    if (ctrl.advance) begin
      unique case (ctrl.word.dig_op)
        gclf_pkg::D_HOLD:        dig <= dig;
        gclf_pkg::D_LOAD4:       dig <= 3'd4;
        gclf_pkg::D_LOAD2:       dig <= 3'd2;
        gclf_pkg::D_DEC_ON_JUMP: dig <= ctrl.jump ? 3'(dig - 3'd1) : dig;
        default:                 dig <= dig;
      endcase
    end
  end

endmodule

`default_nettype wire
